>>> src/b32ad_pkg.sv
// Shared constants, types and checksum/alphabet functions for the Bech32 address decoder.
package b32ad_pkg;

   // Defaults and fixed sizes
   localparam int DEF_MAX_CHARS = 64;
   localparam int PAYLOAD_BYTES = 21;
   localparam int HASH_BYTES    = 20;
   localparam int CHK_W         = 30;
   localparam int SYM_W         = 5;
   localparam int BYTE_W        = 8;
   localparam int IDX_W         = 5;
   localparam int STAT_W        = 3;
   localparam int DELAY_DEPTH   = 6;
   localparam int ACC_W         = 13;
   localparam int BCNT_W        = 4;
   localparam int FILL_W        = 3;

   typedef logic [STAT_W-1:0] status_type;

   // Result status codes
   localparam status_type ST_OK       = 3'd0;
   localparam status_type ST_PREFIX   = 3'd1;
   localparam status_type ST_BAD_CHAR = 3'd2;
   localparam status_type ST_CHECKSUM = 3'd3;
   localparam status_type ST_PADDING  = 3'd4;
   localparam status_type ST_VERSION  = 3'd5;
   localparam status_type ST_LENGTH   = 3'd6;

   // BCH generator terms
   localparam logic [CHK_W-1:0] GEN0 = 30'h3b6a57b2;
   localparam logic [CHK_W-1:0] GEN1 = 30'h26508e6d;
   localparam logic [CHK_W-1:0] GEN2 = 30'h1ea119fa;
   localparam logic [CHK_W-1:0] GEN3 = 30'h3d4233dd;
   localparam logic [CHK_W-1:0] GEN4 = 30'h2a1462b3;

   // One polymod step: shift in five zero bits and fold the top symbol back
   function automatic logic [CHK_W-1:0] poly_step(input logic [CHK_W-1:0] c);
      logic [4:0]       top;
      logic [CHK_W-1:0] r;
      top = c[29:25];
      r   = {c[24:0], 5'b00000};
      if (top[0]) r = r ^ GEN0;
      if (top[1]) r = r ^ GEN1;
      if (top[2]) r = r ^ GEN2;
      if (top[3]) r = r ^ GEN3;
      if (top[4]) r = r ^ GEN4;
      return r;
   endfunction

   // Checksum after the expanded hrp "bc" has been fed in
   function automatic logic [CHK_W-1:0] hrp_seed();
      logic [CHK_W-1:0] c;
      c = 30'd1;
      c = poly_step(c) ^ 30'd3;
      c = poly_step(c) ^ 30'd3;
      c = poly_step(c);
      c = poly_step(c) ^ 30'd2;
      c = poly_step(c) ^ 30'd3;
      return c;
   endfunction

   localparam logic [CHK_W-1:0] CHK_SEED = hrp_seed();

   // Case-insensitive alphabet lookup: {valid, symbol}
   function automatic logic [SYM_W:0] map_char(input logic [7:0] ch);
      logic [7:0]       lc;
      logic [SYM_W:0]   r;
      lc = ((ch >= "A") && (ch <= "Z")) ? ch + 8'd32 : ch;
      case (lc)
         "q": r = {1'b1, 5'd0};
         "p": r = {1'b1, 5'd1};
         "z": r = {1'b1, 5'd2};
         "r": r = {1'b1, 5'd3};
         "y": r = {1'b1, 5'd4};
         "9": r = {1'b1, 5'd5};
         "x": r = {1'b1, 5'd6};
         "8": r = {1'b1, 5'd7};
         "g": r = {1'b1, 5'd8};
         "f": r = {1'b1, 5'd9};
         "2": r = {1'b1, 5'd10};
         "t": r = {1'b1, 5'd11};
         "v": r = {1'b1, 5'd12};
         "d": r = {1'b1, 5'd13};
         "w": r = {1'b1, 5'd14};
         "0": r = {1'b1, 5'd15};
         "s": r = {1'b1, 5'd16};
         "3": r = {1'b1, 5'd17};
         "j": r = {1'b1, 5'd18};
         "n": r = {1'b1, 5'd19};
         "5": r = {1'b1, 5'd20};
         "4": r = {1'b1, 5'd21};
         "k": r = {1'b1, 5'd22};
         "h": r = {1'b1, 5'd23};
         "c": r = {1'b1, 5'd24};
         "e": r = {1'b1, 5'd25};
         "6": r = {1'b1, 5'd26};
         "m": r = {1'b1, 5'd27};
         "u": r = {1'b1, 5'd28};
         "a": r = {1'b1, 5'd29};
         "7": r = {1'b1, 5'd30};
         "l": r = {1'b1, 5'd31};
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

>>> src/b32ad_ifs.sv
// Valid/ready channel interfaces for address characters and decoded results.
interface b32ad_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface b32ad_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [b32ad_pkg::BYTE_W-1:0]         hash_byte;
   logic [b32ad_pkg::IDX_W-1:0]          byte_index;
   logic [b32ad_pkg::STAT_W-1:0]         status;
   logic                                 last_result;

   modport source (output valid, output hash_byte, output byte_index, output status,
                   output last_result, input ready);
   modport sink   (input valid, input hash_byte, input byte_index, input status,
                   input last_result, output ready);
endinterface

>>> src/bech32_address_decoder.sv
// Top level: Bech32 segwit v0 mainnet address decoder with banked byte store.
//
// Usage: req_chan carries one ASCII character per word, last_char marking the
// final character of an address. rsp_chan returns either the 20 hash bytes
// (status ok, byte_index 0..19, last_result on index 19) or one error word
// (hash_byte and byte_index zero, last_result set).
// Throughput: one character per cycle; one result word per cycle. Decoded
// bytes go into a two-bank synchronous byte memory (one bank being filled,
// one being read out), so the next address streams in while results drain.
// The first result word follows the last character through the hand-off, job,
// read stage and output registers, when the readout side is free.
// Once an address has ended, no character of the next one is taken
// (req_chan.ready low) until the address before it has issued its last result
// read, so a short address behind a full decode waits on the readout port.
// Receiver stall: rsp words hold in the output register; the read stage
// behind it holds one more word, and further reads stop.
// Reset (synchronous, active high) clears the decoder state, the pending
// result job and the output register; the byte memory needs no clearing.
module bech32_address_decoder #(
   parameter int MAX_ADDRESS_CHARS = b32ad_pkg::DEF_MAX_CHARS
) (
   input  logic           clock,
   input  logic           reset,
   b32ad_req_if.sink      req_chan,
   b32ad_rsp_if.source    rsp_chan
);

   localparam int PosW = $clog2(MAX_ADDRESS_CHARS + 2);
   localparam int AddrW = b32ad_pkg::IDX_W + 1;

   // Character-side state
   logic [PosW-1:0]                   pos_ff, pos_in;
   logic [1:0]                        flags_ff, flags_in;
   logic [b32ad_pkg::CHK_W-1:0]       chk_ff, chk_in;
   logic [b32ad_pkg::FILL_W-1:0]      fill_ff, fill_in;
   logic [b32ad_pkg::SYM_W-1:0]       sh_ff [b32ad_pkg::DELAY_DEPTH];
   logic [b32ad_pkg::SYM_W-1:0]       sh_in [b32ad_pkg::DELAY_DEPTH];
   logic [b32ad_pkg::ACC_W-1:0]       acc_ff, acc_in;
   logic [b32ad_pkg::BCNT_W-1:0]      cnt_ff, cnt_in;
   logic [b32ad_pkg::IDX_W-1:0]       bc_ff, bc_in;
   logic [b32ad_pkg::BYTE_W-1:0]      ver_ff, ver_in;
   logic                              wb_ff, wb_in;

   // Values after this word, before the end-of-address clear
   logic [PosW-1:0]                   pos_nx;
   logic [1:0]                        flags_nx;
   logic [b32ad_pkg::CHK_W-1:0]       chk_nx;
   logic [b32ad_pkg::FILL_W-1:0]      fill_nx;
   logic [b32ad_pkg::ACC_W-1:0]       acc_nx;
   logic [b32ad_pkg::BCNT_W-1:0]      cnt_nx;
   logic [b32ad_pkg::IDX_W-1:0]       bc_nx;
   logic [b32ad_pkg::BYTE_W-1:0]      ver_nx;
   logic                              restart;

   // Packer helpers
   logic [b32ad_pkg::SYM_W:0]         map_res;
   logic [b32ad_pkg::ACC_W-1:0]       acc2;
   logic [b32ad_pkg::BCNT_W-1:0]      cnt2, cnt3;
   logic                              wr_en;
   logic [b32ad_pkg::BYTE_W-1:0]      wr_byte;
   b32ad_pkg::status_type             end_status;

   // End-of-address hand-off and readout job
   logic                              fin_valid_ff, fin_valid_in;
   b32ad_pkg::status_type             fin_status_ff;
   logic                              fin_bank_ff;
   logic                              job_active_ff, job_active_in;
   logic                              job_bank_ff;
   logic [b32ad_pkg::IDX_W-1:0]       job_idx_ff;
   b32ad_pkg::status_type             job_status_ff;
   logic                              job_last, issue, go, adv, accept;

   // Read stage and output register
   logic [b32ad_pkg::BYTE_W-1:0]      byte_mem_ff [2**AddrW];
   logic [b32ad_pkg::BYTE_W-1:0]      mem_q_ff;
   logic                              rd_valid_ff, rd_valid_in;
   logic [b32ad_pkg::IDX_W-1:0]       rd_idx_ff;
   b32ad_pkg::status_type             rd_status_ff;
   logic                              rd_last_ff;
   logic                              rsp_valid_ff;
   logic [b32ad_pkg::BYTE_W-1:0]      rsp_hash_ff;
   logic [b32ad_pkg::IDX_W-1:0]       rsp_idx_ff;
   b32ad_pkg::status_type             rsp_status_ff;
   logic                              rsp_last_ff;

   assign accept  = req_chan.valid & req_chan.ready;
   assign map_res = b32ad_pkg::map_char(req_chan.char_code);

   // Character decode, checksum, delay line and 5-to-8 packing
   always_comb begin
      pos_nx   = pos_ff;
      flags_nx = flags_ff;
      chk_nx   = chk_ff;
      fill_nx  = fill_ff;
      acc_nx   = acc_ff;
      cnt_nx   = cnt_ff;
      bc_nx    = bc_ff;
      ver_nx   = ver_ff;
      sh_in    = sh_ff;
      restart  = 1'b0;
      wr_en    = 1'b0;
      acc2     = {acc_ff[7:0], sh_ff[b32ad_pkg::DELAY_DEPTH-1]};
      cnt2     = cnt_ff + 4'd5;
      cnt3     = cnt2 - 4'd8;
      wr_byte  = b32ad_pkg::BYTE_W'(acc2 >> cnt3);
      if (accept) begin
         if (pos_ff < PosW'(MAX_ADDRESS_CHARS)) begin
            if (pos_ff == PosW'(0)) begin
               if (req_chan.char_code != "b") flags_nx[0] = 1'b1;
            end else if (pos_ff == PosW'(1)) begin
               if (req_chan.char_code != "c") flags_nx[0] = 1'b1;
            end else if (req_chan.char_code == "1") begin
               restart = 1'b1;
            end else if (pos_ff == PosW'(2)) begin
               flags_nx[0] = 1'b1;
            end else if (!map_res[b32ad_pkg::SYM_W]) begin
               flags_nx[1] = 1'b1;
            end else begin
               chk_nx = b32ad_pkg::poly_step(chk_ff)
                        ^ b32ad_pkg::CHK_W'(map_res[b32ad_pkg::SYM_W-1:0]);
               for (int i = b32ad_pkg::DELAY_DEPTH - 1; i > 0; i--) sh_in[i] = sh_ff[i-1];
               sh_in[0] = map_res[b32ad_pkg::SYM_W-1:0];
               if (fill_ff == b32ad_pkg::FILL_W'(b32ad_pkg::DELAY_DEPTH)) begin
                  // oldest symbol leaves the delay line into the packer
                  if (cnt2 >= 4'd8) begin
                     wr_en  = (bc_ff < b32ad_pkg::IDX_W'(b32ad_pkg::PAYLOAD_BYTES));
                     if (bc_ff == '0) ver_nx = wr_byte;
                     if (bc_ff < b32ad_pkg::IDX_W'(b32ad_pkg::PAYLOAD_BYTES + 1))
                        bc_nx = bc_ff + 5'd1;
                     acc_nx = acc2 & ((13'd1 << cnt3) - 13'd1);
                     cnt_nx = cnt3;
                  end else begin
                     acc_nx = acc2;
                     cnt_nx = cnt2;
                  end
               end else begin
                  fill_nx = fill_ff + 3'd1;
               end
            end
         end
         if (pos_ff <= PosW'(MAX_ADDRESS_CHARS)) pos_nx = pos_ff + PosW'(1);
         if (restart) begin
            chk_nx      = b32ad_pkg::CHK_SEED;
            fill_nx     = '0;
            acc_nx      = '0;
            cnt_nx      = '0;
            bc_nx       = '0;
            flags_nx[1] = 1'b0;
         end
      end
   end

   // Final verdict from the state this word leaves behind
   always_comb begin
      if (flags_nx[0] || (pos_nx < PosW'(3))) begin
         end_status = b32ad_pkg::ST_PREFIX;
      end else if (pos_nx > PosW'(MAX_ADDRESS_CHARS)) begin
         end_status = b32ad_pkg::ST_LENGTH;
      end else if (flags_nx[1]) begin
         end_status = b32ad_pkg::ST_BAD_CHAR;
      end else if (chk_nx != 30'd1) begin
         end_status = b32ad_pkg::ST_CHECKSUM;
      end else if ((cnt_nx >= 4'd5) || ((acc_nx & ((13'd1 << cnt_nx) - 13'd1)) != '0)) begin
         end_status = b32ad_pkg::ST_PADDING;
      end else if (bc_nx == '0) begin
         end_status = b32ad_pkg::ST_LENGTH;
      end else if (ver_nx != '0) begin
         end_status = b32ad_pkg::ST_VERSION;
      end else if (bc_nx != b32ad_pkg::IDX_W'(b32ad_pkg::PAYLOAD_BYTES)) begin
         end_status = b32ad_pkg::ST_LENGTH;
      end else begin
         end_status = b32ad_pkg::ST_OK;
      end
   end

   // End of address: state returns to its start values, write bank flips
   always_comb begin
      if (accept && req_chan.last_char) begin
         pos_in   = '0;
         flags_in = '0;
         chk_in   = b32ad_pkg::CHK_SEED;
         fill_in  = '0;
         acc_in   = '0;
         cnt_in   = '0;
         bc_in    = '0;
         wb_in    = ~wb_ff;
      end else begin
         pos_in   = pos_nx;
         flags_in = flags_nx;
         chk_in   = chk_nx;
         fill_in  = fill_nx;
         acc_in   = acc_nx;
         cnt_in   = cnt_nx;
         bc_in    = bc_nx;
         wb_in    = wb_ff;
      end
      ver_in = ver_nx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         flags_ff <= '0;
         chk_ff   <= b32ad_pkg::CHK_SEED;
         fill_ff  <= '0;
         acc_ff   <= '0;
         cnt_ff   <= '0;
         bc_ff    <= '0;
         wb_ff    <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         flags_ff <= flags_in;
         chk_ff   <= chk_in;
         fill_ff  <= fill_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         bc_ff    <= bc_in;
         wb_ff    <= wb_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff  <= sh_in;
      ver_ff <= ver_in;
   end

   // Readout job control: one word issued per cycle into the read stage while the output is not stalled
   assign adv      = ~rsp_valid_ff | rsp_chan.ready;
   assign issue    = job_active_ff & (~rd_valid_ff | adv);
   assign job_last = (job_status_ff != b32ad_pkg::ST_OK)
                     || (job_idx_ff == b32ad_pkg::IDX_W'(b32ad_pkg::HASH_BYTES - 1));
   assign go       = fin_valid_ff & (~job_active_ff | (issue & job_last));
   assign req_chan.ready = ~fin_valid_ff | go;

   always_comb begin
      fin_valid_in = fin_valid_ff;
      if (go) fin_valid_in = 1'b0;
      if (accept && req_chan.last_char) fin_valid_in = 1'b1;
      job_active_in = job_active_ff;
      if (issue && job_last) job_active_in = 1'b0;
      if (go) job_active_in = 1'b1;
      rd_valid_in = issue | (rd_valid_ff & ~adv);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff  <= 1'b0;
         job_active_ff <= 1'b0;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         fin_valid_ff  <= fin_valid_in;
         job_active_ff <= job_active_in;
         rd_valid_ff   <= rd_valid_in;
         if (adv) rsp_valid_ff <= rd_valid_ff;
      end
   end

   // Job and hand-off payload
   always_ff @(posedge clock) begin
      if (accept && req_chan.last_char) begin
         fin_status_ff <= end_status;
         fin_bank_ff   <= wb_ff;
      end
      if (go) begin
         job_bank_ff   <= fin_bank_ff;
         job_status_ff <= fin_status_ff;
         job_idx_ff    <= '0;
      end else if (issue) begin
         job_idx_ff    <= job_idx_ff + 5'd1;
      end
      if (issue) begin
         rd_idx_ff    <= job_idx_ff;
         rd_status_ff <= job_status_ff;
         rd_last_ff   <= job_last;
      end
      if (adv && rd_valid_ff) begin
         rsp_hash_ff   <= (rd_status_ff == b32ad_pkg::ST_OK) ? mem_q_ff : '0;
         rsp_idx_ff    <= (rd_status_ff == b32ad_pkg::ST_OK) ? rd_idx_ff : '0;
         rsp_status_ff <= rd_status_ff;
         rsp_last_ff   <= rd_last_ff;
      end
   end

   // Two-bank byte store: written by the packer, read by the readout job
   always_ff @(posedge clock) begin
      if (wr_en) byte_mem_ff[{wb_ff, bc_ff}] <= wr_byte;
      if (issue) mem_q_ff <= byte_mem_ff[{job_bank_ff, job_idx_ff + 5'd1}];
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.hash_byte   = rsp_hash_ff;
   assign rsp_chan.byte_index  = rsp_idx_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.last_result = rsp_last_ff;

endmodule

>>> src/b32ad_checker.sv
// Port-level checker for the Bech32 address decoder, bound to the top level.
module b32ad_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [b32ad_pkg::BYTE_W-1:0]       hash_byte,
   input logic [b32ad_pkg::IDX_W-1:0]        byte_index,
   input logic [b32ad_pkg::STAT_W-1:0]       status,
   input logic                               last_result
);

   // No result word right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid after reset");

   // An error word is a lone, zeroed, final word
   a_error_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && status != b32ad_pkg::ST_OK) |->
         (hash_byte == '0 && byte_index == '0 && last_result))
      else $error("malformed error word");

   // Hash words end exactly at the last index
   a_hash_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && status == b32ad_pkg::ST_OK) |->
         (last_result == (byte_index == b32ad_pkg::IDX_W'(b32ad_pkg::HASH_BYTES - 1))))
      else $error("last_result does not match final hash index");

   // A stalled word holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(hash_byte) && $stable(byte_index) && $stable(status)
          && $stable(last_result)))
      else $error("stalled result word changed");

endmodule

bind bech32_address_decoder b32ad_checker u_b32ad_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .hash_byte   (rsp_chan.hash_byte),
   .byte_index  (rsp_chan.byte_index),
   .status      (rsp_chan.status),
   .last_result (rsp_chan.last_result)
);
